// File: hdl/label_bounding_box_accumulator_core_assert.svh
// assertion macros for the checker file of the label box accumulator
// no dependencies; expects signals clk and rst_n in the including scope
`ifndef LABEL_BOUNDING_BOX_ACCUMULATOR_CORE_ASSERT_SVH
`define LABEL_BOUNDING_BOX_ACCUMULATOR_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define LBBA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbba assertion failed");

// next-cycle implication, held off during reset
`define LBBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbba assertion failed");

`endif

// File: hdl/lbba_pkg.sv
// types and constants of the label bounding box accumulator
// no dependencies
package lbba_pkg;

  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int LABEL_W   = 16;
  localparam int BOX_IDX_W = 10;
  localparam int OUT_W     = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEPTH  = 2'd2;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd4096;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd4096;
  localparam logic [CFG_W-1:0] DEPTH_RESET  = 13'd1;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_READ  = 1'b1
  } lbba_kind_t;

  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } lbba_state_t;

  typedef struct packed {
    lbba_kind_t           kind;
    logic [LABEL_W-1:0]   label;
    logic [BOX_IDX_W-1:0] box_index;
  } lbba_in_t;

  typedef struct packed {
    logic             status;
    logic             frame_end;
    logic             present;
    logic [OUT_W-1:0] min_x;
    logic [OUT_W-1:0] min_y;
    logic [OUT_W-1:0] min_z;
    logic [OUT_W-1:0] max_x;
    logic [OUT_W-1:0] max_y;
    logic [OUT_W-1:0] max_z;
  } lbba_out_t;

endpackage

// File: hdl/lbba_ram.sv
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module lbba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/label_bounding_box_accumulator_core.sv
// label bounding box accumulator: per-label min/max x, y, z in one ram
// result passes the modify stage then the output register; one transaction per cycle
// sustained unless the output stalls, set by the single read-modify-write of box ram
// after reset the ram is swept to empty, all NUM_LABELS entries, with in_ready low
// depends on lbba_pkg and lbba_ram
module label_bounding_box_accumulator_core #(
  parameter int NUM_LABELS = 1024,
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  lbba_pkg::lbba_in_t                     in_data,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output lbba_pkg::lbba_out_t                    out_data,
  input  logic                                   cfg_we,
  input  logic [lbba_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lbba_pkg::CFG_W-1:0]             cfg_data
);
  import lbba_pkg::*;

  localparam int ADDR_W = $clog2(NUM_LABELS);
  localparam int CB     = COORD_BITS;
  // entry layout: seen, min x y z, max x y z
  localparam int E_W    = 1 + 6 * CB;
  localparam int SEEN_B = 6 * CB;
  // size compare width: holds both a config value and 2^COORD_BITS
  localparam int SZ_W   = (CB + 1 > CFG_W) ? CB + 1 : CFG_W;
  localparam logic [E_W-1:0] EMPTY_ENTRY = {1'b0, {(3 * CB){1'b1}}, {(3 * CB){1'b0}}};

  // clamp a size register: zero acts as one, above 2^COORD_BITS saturates
  function automatic logic [SZ_W-1:0] eff_size(input logic [CFG_W-1:0] v);
    logic [SZ_W-1:0] lim;
    logic [SZ_W-1:0] r;
    lim = SZ_W'(1) << CB;
    r   = SZ_W'(v);
    if (r == '0) begin
      return SZ_W'(1);
    end else if (r > lim) begin
      return lim;
    end
    return r;
  endfunction

  // configuration registers
  logic [CFG_W-1:0] width_r, height_r, depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      depth_r  <= DEPTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_WIDTH:  width_r  <= cfg_data;
        CFG_IDX_HEIGHT: height_r <= cfg_data;
        CFG_IDX_DEPTH:  depth_r  <= cfg_data;
        default: ;  // index beyond the register list is dropped
      endcase
    end
  end

  // clearing sweep after reset
  lbba_state_t      state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              clr_last;
  logic              clr_we;
  logic              running;

  assign clr_last = (clr_cnt_r == ADDR_W'(NUM_LABELS - 1));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_last) state_nxt = ST_RUN;
      ST_RUN:   state_nxt = ST_RUN;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    clr_we  = 1'b0;
    running = 1'b0;
    unique case (state_r)
      ST_CLEAR: clr_we  = 1'b1;
      ST_RUN:   running = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (clr_we) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
    end
  end

  // handshake between the read stage, the modify stage and the output register
  logic s1_valid_r;
  logic s1_fire;
  logic in_acc;
  logic out_valid_r;
  lbba_out_t out_data_r;

  assign s1_fire  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = running && (!s1_valid_r || s1_fire);
  assign in_acc   = in_valid && in_ready;

  // position counters, advanced when a pixel transaction is taken
  logic [CB-1:0] cur_x_r, cur_y_r, cur_z_r;
  logic [SZ_W-1:0] x_inc, y_inc, z_inc;
  logic xe, ye, ze;
  logic is_pixel;

  assign is_pixel = (in_data.kind == KIND_PIXEL);
  assign x_inc = SZ_W'(cur_x_r) + SZ_W'(1);
  assign y_inc = SZ_W'(cur_y_r) + SZ_W'(1);
  assign z_inc = SZ_W'(cur_z_r) + SZ_W'(1);
  // a counter beyond a freshly shrunk limit wraps on its next advance
  assign xe = (x_inc >= eff_size(width_r));
  assign ye = (y_inc >= eff_size(height_r));
  assign ze = (z_inc >= eff_size(depth_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
      cur_z_r <= '0;
    end else if (in_acc && is_pixel) begin
      if (!xe) begin
        cur_x_r <= x_inc[CB-1:0];
      end else begin
        cur_x_r <= '0;
        if (!ye) begin
          cur_y_r <= y_inc[CB-1:0];
        end else begin
          cur_y_r <= '0;
          cur_z_r <= ze ? '0 : z_inc[CB-1:0];
        end
      end
    end
  end

  // address decode for the incoming transaction
  logic              label_ok;
  logic              bidx_ok;
  logic [LABEL_W-1:0] label_m1;
  logic [16:0]       bidx_ext;
  logic [ADDR_W-1:0] rd_addr;

  assign label_ok = (in_data.label != '0) && ({1'b0, in_data.label} <= 17'(NUM_LABELS));
  assign bidx_ext = {7'b0, in_data.box_index};
  assign bidx_ok  = (bidx_ext < 17'(NUM_LABELS));
  assign label_m1 = in_data.label - LABEL_W'(1);
  assign rd_addr  = is_pixel ? label_m1[ADDR_W-1:0] : bidx_ext[ADDR_W-1:0];

  // box ram write port, shared by the clearing sweep and the modify stage
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [E_W-1:0]    wr_data;
  logic [E_W-1:0]    upd_data;
  logic              s1_wr_en;
  logic [E_W-1:0]    ram_rdata;
  logic [ADDR_W-1:0] s1_addr_r;

  assign wr_en   = clr_we || s1_wr_en;
  assign wr_addr = clr_we ? clr_cnt_r : s1_addr_r;
  assign wr_data = clr_we ? EMPTY_ENTRY : upd_data;

  lbba_ram #(
    .WIDTH (E_W),
    .DEPTH (NUM_LABELS)
  ) u_box_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (in_acc),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // modify stage registers
  lbba_kind_t        s1_kind_r;
  logic              s1_write_r;
  logic              s1_inrange_r;
  logic              s1_status_r;
  logic              s1_fend_r;
  logic [CB-1:0]     s1_x_r, s1_y_r, s1_z_r;
  // the ram read raced a write to the same entry: take the written value
  logic              s1_fwd_r;
  logic [E_W-1:0]    fwd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r    <= in_data.kind;
      s1_inrange_r <= bidx_ok;
      s1_write_r   <= is_pixel ? label_ok : bidx_ok;
      s1_addr_r    <= rd_addr;
      s1_status_r  <= is_pixel && !label_ok;
      s1_fend_r    <= is_pixel && xe && ye && ze;
      s1_x_r       <= cur_x_r;
      s1_y_r       <= cur_y_r;
      s1_z_r       <= cur_z_r;
      s1_fwd_r     <= wr_en && (wr_addr == rd_addr);
      fwd_data_r   <= wr_data;
    end
  end

  // merge the pixel position into the stored box
  logic [E_W-1:0] cur_entry;
  logic [E_W-1:0] merged;
  logic [CB-1:0]  coord [3];
  logic [CB-1:0]  old_min, old_max;

  assign cur_entry = s1_fwd_r ? fwd_data_r : ram_rdata;
  assign coord[0]  = s1_x_r;
  assign coord[1]  = s1_y_r;
  assign coord[2]  = s1_z_r;

  always_comb begin
    merged         = cur_entry;
    merged[SEEN_B] = 1'b1;
    old_min        = '0;
    old_max        = '0;
    for (int k = 0; k < 3; k++) begin
      old_min = cur_entry[(5 - k) * CB +: CB];
      old_max = cur_entry[(2 - k) * CB +: CB];
      if (coord[k] < old_min) begin
        merged[(5 - k) * CB +: CB] = coord[k];
      end
      if (coord[k] > old_max) begin
        merged[(2 - k) * CB +: CB] = coord[k];
      end
    end
  end

  // a read clears the entry back to empty
  assign upd_data = (s1_kind_r == KIND_PIXEL) ? merged : EMPTY_ENTRY;
  assign s1_wr_en = s1_fire && s1_write_r;

  // result assembly
  lbba_out_t res;
  logic [E_W-1:0] rd_entry;

  assign rd_entry = s1_inrange_r ? cur_entry : EMPTY_ENTRY;

  always_comb begin
    res = '0;
    unique case (s1_kind_r)
      KIND_PIXEL: begin
        res.status    = s1_status_r;
        res.frame_end = s1_fend_r;
      end
      KIND_READ: begin
        res.present = rd_entry[SEEN_B];
        res.min_x   = OUT_W'(rd_entry[5 * CB +: CB]);
        res.min_y   = OUT_W'(rd_entry[4 * CB +: CB]);
        res.min_z   = OUT_W'(rd_entry[3 * CB +: CB]);
        res.max_x   = OUT_W'(rd_entry[2 * CB +: CB]);
        res.max_y   = OUT_W'(rd_entry[1 * CB +: CB]);
        res.max_z   = OUT_W'(rd_entry[0 +: CB]);
      end
      default: ;
    endcase
  end

  // output register: holds a result while the next transaction is read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/lbba_checker.sv
// port-level checks on the label box accumulator, bound to the top level
// depends on lbba_pkg and the assertion macro header
`include "label_bounding_box_accumulator_core_assert.svh"

module lbba_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input lbba_pkg::lbba_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input lbba_pkg::lbba_out_t out_data
);
  import lbba_pkg::*;

  // a stalled result transaction holds
  `LBBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // a present box never carries pixel status bits
  `LBBA_ASSERT_NOW(a_present_no_pixel, out_valid && out_data.present,
                   !out_data.status && !out_data.frame_end)

  // a present box has min not above max on every axis
  `LBBA_ASSERT_NOW(a_box_ordered, out_valid && out_data.present,
                   (out_data.min_x <= out_data.max_x) && (out_data.min_y <= out_data.max_y) &&
                   (out_data.min_z <= out_data.max_z))

  // an empty read returns zero maxima
  `LBBA_ASSERT_NOW(a_empty_read, out_valid && !out_data.present && (out_data.min_x != '0),
                   (out_data.max_x == '0) && (out_data.max_y == '0) && (out_data.max_z == '0))

endmodule

bind label_bounding_box_accumulator_core lbba_checker u_lbba_checker (.*);
